// ===== rtl/tar_pkg.sv =====
// Shared types, command and register codes, and the divide-by-scale helper.
`timescale 1ns / 1ps

package tar_pkg;

  localparam logic [1:0] CMD_WR_GLYPH   = 2'd0;
  localparam logic [1:0] CMD_WR_ATTR    = 2'd1;
  localparam logic [1:0] CMD_SET_BORDER = 2'd2;
  localparam logic [1:0] CMD_RENDER     = 2'd3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLUMNS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ROWS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_LINE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PIXELS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LINES  = 3'd5;

  localparam logic [6:0]  RST_TEXT_COLUMNS  = 7'd32;
  localparam logic [5:0]  RST_TEXT_ROWS     = 6'd24;
  localparam logic [2:0]  RST_SCALE         = 3'd2;
  localparam logic [9:0]  RST_START_LINE    = 10'd0;
  localparam logic [10:0] RST_ACTIVE_PIXELS = 11'd640;
  localparam logic [9:0]  RST_ACTIVE_LINES  = 10'd480;

  // index widths cover the largest stores the size parameters allow
  localparam int GIDX_W  = 16;
  localparam int AIDX_W  = 13;
  localparam int GLYPH_W = 8;
  localparam int ATTR_W  = 16;
  localparam int COLOR_W = 8;

  // reciprocals for x / d with x below 2^11, exact with a 16-bit shift
  localparam int RECIP_SHIFT = 16;
  localparam logic [15:0] RECIP_3 = 16'd21846;
  localparam logic [15:0] RECIP_5 = 16'd13108;
  localparam logic [15:0] RECIP_6 = 16'd10923;
  localparam logic [15:0] RECIP_7 = 16'd9363;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] address;
    logic [15:0] write_data;
    logic [9:0]  video_line;
    logic [10:0] pixel_x;
  } cmd_item_t;

  typedef struct packed {
    logic [6:0]  text_columns;
    logic [5:0]  text_rows;
    logic [2:0]  scale;
    logic [9:0]  start_line;
    logic [10:0] active_pixels;
    logic [9:0]  active_lines;
  } geom_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        command;
    logic [13:0]       address;
    logic [15:0]       write_data;
    logic              border;
    logic [GIDX_W-1:0] gidx;
    logic [AIDX_W-1:0] aidx;
    logic [2:0]        bit_sel;
  } pix_req_t;

  // scale of zero behaves as one
  function automatic logic [10:0] div_by_scale(input logic [10:0] x, input logic [2:0] d);
    logic [26:0] p;
    p = '0;
    case (d)
      3'd2: p = {16'd0, x} << (RECIP_SHIFT - 1);
      3'd3: p = 27'(x) * 27'(RECIP_3);
      3'd4: p = {16'd0, x} << (RECIP_SHIFT - 2);
      3'd5: p = 27'(x) * 27'(RECIP_5);
      3'd6: p = 27'(x) * 27'(RECIP_6);
      3'd7: p = 27'(x) * 27'(RECIP_7);
      default: p = {16'd0, x} << RECIP_SHIFT;
    endcase
    return p[RECIP_SHIFT+10:RECIP_SHIFT];
  endfunction

endpackage

// ===== rtl/tar_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module tar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tar_addr_pipe.sv =====
// Four-stage geometry pipeline: scaling, borders, area test and store indices.
`timescale 1ns / 1ps

module tar_addr_pipe #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  tar_pkg::cmd_item_t  in_item,
  input  tar_pkg::geom_cfg_t  cfg,
  output tar_pkg::pix_req_t   req
);
  import tar_pkg::*;

  localparam int GLYPH_DEPTH = MAX_COLUMNS * MAX_ROWS * 8;
  localparam int ATTR_DEPTH  = MAX_COLUMNS * MAX_ROWS;

  typedef struct packed {
    logic        valid;
    cmd_item_t   item;
    logic        pre_start;
    logic [9:0]  diff;
    logic [10:0] hres;
    logic [9:0]  vres;
    logic [2:0]  sc;
    logic [7:0]  cols;
    logic [6:0]  rows;
  } st1_t;

  typedef struct packed {
    logic        valid;
    cmd_item_t   item;
    logic        pre_start;
    logic [9:0]  sline;
    logic [10:0] hres;
    logic [9:0]  vres;
    logic [10:0] hb;
    logic [9:0]  vb;
    logic [7:0]  cols;
    logic [10:0] tw;
    logic [9:0]  th;
  } st2_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  command;
    logic [13:0] address;
    logic [15:0] write_data;
    logic        border;
    logic [9:0]  vline;
    logic [7:0]  col;
    logic [2:0]  bit_sel;
    logic [7:0]  cols;
  } st3_t;

  st1_t     s1, s1_next;
  st2_t     s2, s2_next;
  st3_t     s3, s3_next;
  pix_req_t s4_next;

  logic [7:0]  tc_ext;
  logic [6:0]  tr_ext;
  logic [10:0] px;
  logic [9:0]  vline;
  logic [17:0] gfull;
  logic [14:0] afull;

  // stage 1: line offset, scaled resolution, saturated text size
  always_comb begin
    tc_ext            = {1'b0, cfg.text_columns};
    tr_ext            = {1'b0, cfg.text_rows};
    s1_next.valid     = in_valid;
    s1_next.item      = in_item;
    s1_next.pre_start = in_item.video_line < cfg.start_line;
    s1_next.diff      = in_item.video_line - cfg.start_line;
    s1_next.hres      = div_by_scale(cfg.active_pixels, cfg.scale);
    s1_next.vres      = 10'(div_by_scale({1'b0, cfg.active_lines}, cfg.scale));
    s1_next.sc        = cfg.scale;
    s1_next.cols      = (tc_ext > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : tc_ext;
    s1_next.rows      = (tr_ext > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : tr_ext;
  end

  // stage 2: scaled line and centring borders
  always_comb begin
    s2_next.valid     = s1.valid;
    s2_next.item      = s1.item;
    s2_next.pre_start = s1.pre_start;
    s2_next.sline     = 10'(div_by_scale({1'b0, s1.diff}, s1.sc));
    s2_next.hres      = s1.hres;
    s2_next.vres      = s1.vres;
    s2_next.cols      = s1.cols;
    s2_next.tw        = {s1.cols, 3'b000};
    s2_next.th        = {s1.rows, 3'b000};
    s2_next.hb        = (s1.hres > s2_next.tw) ? ((s1.hres - s2_next.tw) >> 1) : 11'd0;
    s2_next.vb        = (s1.vres > s2_next.th) ? ((s1.vres - s2_next.th) >> 1) : 10'd0;
  end

  // stage 3: inside-area test
  always_comb begin
    vline              = s2.sline - s2.vb;
    px                 = s2.item.pixel_x - s2.hb;
    s3_next.valid      = s2.valid;
    s3_next.command    = s2.item.command;
    s3_next.address    = s2.item.address;
    s3_next.write_data = s2.item.write_data;
    s3_next.border     = s2.pre_start
                       || (s2.sline < s2.vb)
                       || (s2.sline >= s2.vres - s2.vb)
                       || (vline >= s2.th)
                       || (s2.item.pixel_x >= s2.hres)
                       || (s2.item.pixel_x < s2.hb)
                       || (px >= s2.tw);
    s3_next.vline      = vline;
    s3_next.col        = px[10:3];
    s3_next.bit_sel    = px[2:0];
    s3_next.cols       = s2.cols;
  end

  // stage 4: glyph byte and attribute cell indices
  always_comb begin
    gfull              = {8'd0, s3.vline} * {10'd0, s3.cols} + {10'd0, s3.col};
    afull              = {8'd0, s3.vline[9:3]} * {7'd0, s3.cols} + {7'd0, s3.col};
    s4_next.valid      = s3.valid;
    s4_next.command    = s3.command;
    s4_next.address    = s3.address;
    s4_next.write_data = s3.write_data;
    s4_next.border     = s3.border
                       || (32'(gfull) >= 32'(GLYPH_DEPTH))
                       || (32'(afull) >= 32'(ATTR_DEPTH));
    s4_next.gidx       = GIDX_W'(gfull);
    s4_next.aidx       = AIDX_W'(afull);
    s4_next.bit_sel    = s3.bit_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      s3.valid  <= 1'b0;
      req.valid <= 1'b0;
    end else if (adv) begin
      s1  <= s1_next;
      s2  <= s2_next;
      s3  <= s3_next;
      req <= s4_next;
    end
  end

endmodule

// ===== rtl/text_attribute_rasterizer_unit.sv =====
// Attribute text-mode rasterizer: top level with stores, border and result register.
//
// Requests arrive on the cmd channel (cmd_valid / cmd_stall) carrying command,
// address, write_data, video_line and pixel_x. Glyph, attribute and border
// writes give no result; each render request gives one pixel_color on the pix
// channel (pix_valid / pix_stall). Geometry registers are written through the
// cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data); the user must write them
// only while idle, which the block does not enforce. cfg_ready is always high.
// One request is taken every cycle while cmd_stall is low. A render passes
// through four geometry stages, one store read stage, then the result register,
// which raises pix_valid. Order of writes and renders is kept because the
// stores are written and read in the same stage.
// While pix_valid is high and pix_stall is asserted the whole pipeline holds and
// cmd_stall is raised; nothing is dropped or duplicated.
// Reset clears all pipeline valid bits, the border colour and sets the geometry
// registers to their defaults. Glyph and attribute stores hold no reset value.
`timescale 1ns / 1ps

module text_attribute_rasterizer_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic [1:0]                       command,
  input  logic [13:0]                      address,
  input  logic [15:0]                      write_data,
  input  logic [9:0]                       video_line,
  input  logic [10:0]                      pixel_x,
  output logic                             pix_valid,
  input  logic                             pix_stall,
  output logic [7:0]                       pixel_color,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tar_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tar_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tar_pkg::*;

  localparam int GLYPH_DEPTH = MAX_COLUMNS * MAX_ROWS * 8;
  localparam int ATTR_DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int GW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam int AW = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;

  typedef struct packed {
    logic               valid;
    logic               render;
    logic               border;
    logic [2:0]         bit_sel;
    logic [COLOR_W-1:0] border_color;
  } st5_t;

  geom_cfg_t          cfg;
  cmd_item_t          in_item;
  pix_req_t           req;
  st5_t               s5, s5_next;
  logic               adv;
  logic [COLOR_W-1:0] border_color;
  logic               g_we, g_re, a_we, a_re;
  logic [GLYPH_W-1:0] glyph_q;
  logic [ATTR_W-1:0]  attr_q;
  logic               pix_bit;

  assign adv       = !(pix_valid && pix_stall);
  assign cmd_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_columns  <= RST_TEXT_COLUMNS;
      cfg.text_rows     <= RST_TEXT_ROWS;
      cfg.scale         <= RST_SCALE;
      cfg.start_line    <= RST_START_LINE;
      cfg.active_pixels <= RST_ACTIVE_PIXELS;
      cfg.active_lines  <= RST_ACTIVE_LINES;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEXT_COLUMNS:  cfg.text_columns  <= cfg_data[6:0];
        REG_TEXT_ROWS:     cfg.text_rows     <= cfg_data[5:0];
        REG_SCALE:         cfg.scale         <= cfg_data[2:0];
        REG_START_LINE:    cfg.start_line    <= cfg_data[9:0];
        REG_ACTIVE_PIXELS: cfg.active_pixels <= cfg_data;
        REG_ACTIVE_LINES:  cfg.active_lines  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{command: command, address: address, write_data: write_data,
                     video_line: video_line, pixel_x: pixel_x};

  tar_addr_pipe #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_addr_pipe (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (cmd_valid),
    .in_item  (in_item),
    .cfg      (cfg),
    .req      (req)
  );

  // writes and render reads share one stage, so request order is kept
  assign g_we = adv && req.valid && (req.command == CMD_WR_GLYPH)
              && (32'(req.address) < 32'(GLYPH_DEPTH));
  assign a_we = adv && req.valid && (req.command == CMD_WR_ATTR)
              && (32'(req.address) < 32'(ATTR_DEPTH));
  assign g_re = adv && req.valid && (req.command == CMD_RENDER);
  assign a_re = g_re;

  tar_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_DEPTH),
    .AW    (GW)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (GW'(req.address)),
    .wdata (req.write_data[GLYPH_W-1:0]),
    .re    (g_re),
    .raddr (GW'(req.gidx)),
    .rdata (glyph_q)
  );

  tar_ram #(
    .WIDTH (ATTR_W),
    .DEPTH (ATTR_DEPTH),
    .AW    (AW)
  ) u_attr_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(req.address)),
    .wdata (req.write_data),
    .re    (a_re),
    .raddr (AW'(req.aidx)),
    .rdata (attr_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      border_color <= '0;
    end else if (adv && req.valid && (req.command == CMD_SET_BORDER)) begin
      border_color <= req.write_data[COLOR_W-1:0];
    end
  end

  always_comb begin
    s5_next.valid        = req.valid;
    s5_next.render       = req.command == CMD_RENDER;
    s5_next.border       = req.border;
    s5_next.bit_sel      = req.bit_sel;
    s5_next.border_color = border_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.valid <= 1'b0;
    end else if (adv) begin
      s5 <= s5_next;
    end
  end

  // bits are taken MSB first
  assign pix_bit = glyph_q[3'd7 - s5.bit_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (adv) begin
      pix_valid <= s5.valid && s5.render;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s5.border) begin
        pixel_color <= s5.border_color;
      end else if (pix_bit) begin
        pixel_color <= attr_q[15:8];
      end else begin
        pixel_color <= attr_q[7:0];
      end
    end
  end

`ifndef SYNTH
  a_store_port: assert property (@(posedge clk) disable iff (rst)
    !(g_we && g_re) && !(a_we && a_re))
    else $error("store written and read by the same request");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pix_valid) |-> $past(s5.valid && s5.render))
    else $error("result without a render request behind it");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s5) && $stable(req))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

// ===== tb/tb_text_attribute_rasterizer_unit.sv =====
// Self-checking testbench for the attribute text-mode rasterizer.
`timescale 1ns / 1ps

module tb_text_attribute_rasterizer_unit;
  import tar_pkg::*;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 32;
  localparam int GLYPH_DEPTH = MAX_COLUMNS * MAX_ROWS * 8;
  localparam int ATTR_DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  logic [1:0]  command;
  logic [13:0] address;
  logic [15:0] write_data;
  logic [9:0]  video_line;
  logic [10:0] pixel_x;
  logic        pix_valid;
  logic        pix_stall = 1'b0;
  logic [7:0]  pixel_color;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // shadow of the block's state
  geom_cfg_t   geom;
  logic [7:0]  glyph_mem [GLYPH_DEPTH];
  logic [15:0] attr_mem [ATTR_DEPTH];
  bit          glyph_written [GLYPH_DEPTH];
  bit          attr_written [ATTR_DEPTH];
  logic [7:0]  border_shadow;

  logic [7:0]  expected_pixels [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          requests_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  text_attribute_rasterizer_unit #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .address(address), .write_data(write_data),
    .video_line(video_line), .pixel_x(pixel_x),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pixel_color(pixel_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[text_attribute_rasterizer_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
      pix_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_color: no request outstanding, got %0h", pixel_color);
        error_count++;
      end else begin
        if (pixel_color !== expected_pixels[0]) begin
          $error("pixel_color: expected %0h, actual %0h", expected_pixels[0], pixel_color);
          error_count++;
        end
        void'(expected_pixels.pop_front());
      end
    end
  end

  // Scaled text window: first line/column of the text area and how many fall on screen.
  function automatic void text_window(output int sc, output int cols, output int rows,
                                      output int y0, output int ny,
                                      output int x0, output int nx);
    int hres, vres, tw, th, y_end, x_end;
    sc   = (geom.scale == 3'd0) ? 1 : int'(geom.scale);
    cols = (int'(geom.text_columns) > MAX_COLUMNS) ? MAX_COLUMNS : int'(geom.text_columns);
    rows = (int'(geom.text_rows) > MAX_ROWS) ? MAX_ROWS : int'(geom.text_rows);
    hres = int'(geom.active_pixels) / sc;
    vres = int'(geom.active_lines) / sc;
    tw = cols * 8;
    th = rows * 8;
    x0 = (hres > tw) ? (hres - tw) / 2 : 0;
    y0 = (vres > th) ? (vres - th) / 2 : 0;
    // vertical limit is symmetric, horizontal one is the screen edge
    y_end = (vres - y0 < y0 + th) ? vres - y0 : y0 + th;
    x_end = (hres < x0 + tw) ? hres : x0 + tw;
    ny = y_end - y0;
    nx = x_end - x0;
  endfunction

  function automatic bit locate_cell(input int line, input int x,
                                     output int gidx, output int aidx, output int bit_pos);
    int sc, cols, rows, y0, ny, x0, nx, sline, vline, px;
    text_window(sc, cols, rows, y0, ny, x0, nx);
    gidx = 0;
    aidx = 0;
    bit_pos = 0;
    if (line < int'(geom.start_line)) return 1'b0;
    sline = (line - int'(geom.start_line)) / sc;
    if (sline < y0 || sline >= y0 + ny || x < x0 || x >= x0 + nx) return 1'b0;
    vline = sline - y0;
    px = x - x0;
    gidx = vline * cols + px / 8;
    aidx = (vline / 8) * cols + px / 8;
    bit_pos = 7 - (px % 8);
    return 1'b1;
  endfunction

  function automatic logic [7:0] predict_pixel(input int line, input int x);
    int gidx, aidx, bit_pos;
    if (!locate_cell(line, x, gidx, aidx, bit_pos)) return border_shadow;
    return glyph_mem[gidx][bit_pos] ? attr_mem[aidx][15:8] : attr_mem[aidx][7:0];
  endfunction

  function automatic cmd_item_t make_item(input logic [1:0] cmd, input int addr,
                                          input logic [15:0] data);
    cmd_item_t it;
    it = cmd_item_t'(53'({$urandom, $urandom}));
    it.command = cmd;
    it.address = 14'(addr);
    it.write_data = data;
    return it;
  endfunction

  task automatic send_item(input cmd_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid   <= 1'b1;
    command     <= it.command;
    address     <= it.address;
    write_data  <= it.write_data;
    video_line  <= it.video_line;
    pixel_x     <= it.pixel_x;
    do @(posedge clk); while (cmd_stall);
    requests_sent++;
    case (it.command)
      CMD_WR_GLYPH: begin
        glyph_mem[it.address] = it.write_data[7:0];
        glyph_written[it.address] = 1'b1;
      end
      CMD_WR_ATTR: begin
        if (int'(it.address) < ATTR_DEPTH) begin
          attr_mem[it.address] = it.write_data;
          attr_written[it.address] = 1'b1;
        end
      end
      CMD_SET_BORDER: border_shadow = it.write_data[7:0];
      default: expected_pixels.push_back(predict_pixel(int'(it.video_line),
                                                       int'(it.pixel_x)));
    endcase
  endtask

  // Loads any store entry the pixel would read that has never been written, then renders.
  task automatic render_at(input int line, input int x);
    int gidx, aidx, bit_pos;
    cmd_item_t it;
    if (locate_cell(line, x, gidx, aidx, bit_pos)) begin
      if (!glyph_written[gidx]) send_item(make_item(CMD_WR_GLYPH, gidx, 16'($urandom)));
      if (!attr_written[aidx]) send_item(make_item(CMD_WR_ATTR, aidx, 16'($urandom)));
    end
    it = make_item(CMD_RENDER, $urandom_range(0, 16383), 16'($urandom));
    it.video_line = 10'(line);
    it.pixel_x = 11'(x);
    send_item(it);
  endtask

  task automatic render_random();
    int sc, cols, rows, y0, ny, x0, nx, roll, line, x, base;
    text_window(sc, cols, rows, y0, ny, x0, nx);
    roll = $urandom_range(0, 99);
    line = $urandom_range(0, 1023);
    x = $urandom_range(0, 2047);
    base = int'(geom.start_line);
    if (roll < 70 && ny > 0 && nx > 0) begin
      line = base + (y0 + $urandom_range(0, ny - 1)) * sc + $urandom_range(0, sc - 1);
      x = x0 + $urandom_range(0, nx - 1);
    end else if (roll < 88) begin
      // just inside or just outside the edges of the text area
      case ($urandom_range(0, 3))
        0: line = base - 1;
        1: line = base + y0 * sc - 1;
        2: line = base + (y0 + ny) * sc - 1;
        default: line = base + (y0 + ny) * sc;
      endcase
      case ($urandom_range(0, 3))
        0: x = x0 - 1;
        1: x = x0;
        2: x = x0 + nx - 1;
        default: x = x0 + nx;
      endcase
    end
    if (line < 0 || line > 1023) line = $urandom_range(0, 1023);
    if (x < 0 || x > 2047) x = $urandom_range(0, 2047);
    render_at(line, x);
  endtask

  task automatic random_request();
    int sc, cols, rows, y0, ny, x0, nx, roll, addr;
    text_window(sc, cols, rows, y0, ny, x0, nx);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      render_random();
    end else if (roll < 75) begin
      addr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GLYPH_DEPTH - 1)
                                         : $urandom_range(0, cols * rows * 8 - 1);
      send_item(make_item(CMD_WR_GLYPH, addr, 16'($urandom)));
    end else if (roll < 92) begin
      addr = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 16383)
                                         : $urandom_range(0, cols * rows - 1);
      send_item(make_item(CMD_WR_ATTR, addr, 16'($urandom)));
    end else begin
      send_item(make_item(CMD_SET_BORDER, $urandom_range(0, 16383), 16'($urandom)));
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_TEXT_COLUMNS:  geom.text_columns  = value[6:0];
      REG_TEXT_ROWS:     geom.text_rows     = value[5:0];
      REG_SCALE:         geom.scale         = value[2:0];
      REG_START_LINE:    geom.start_line    = value[9:0];
      REG_ACTIVE_PIXELS: geom.active_pixels = value[10:0];
      REG_ACTIVE_LINES:  geom.active_lines  = value[9:0];
      default: ;
    endcase
  endtask

  // Registers are only touched once the pipeline has drained.
  task automatic apply_geometry(input geom_cfg_t g, input bit with_spare);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_register(REG_TEXT_COLUMNS, 11'(g.text_columns));
    write_register(REG_TEXT_ROWS, 11'(g.text_rows));
    write_register(REG_SCALE, 11'(g.scale));
    write_register(REG_START_LINE, 11'(g.start_line));
    write_register(REG_ACTIVE_PIXELS, g.active_pixels);
    write_register(REG_ACTIVE_LINES, 11'(g.active_lines));
    if (with_spare) begin
      write_register(REG_SPARE_6, 11'($urandom));
      write_register(REG_SPARE_7, 11'h7ff);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic geom_cfg_t random_geometry();
    geom_cfg_t g;
    g.text_columns = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(65, 127)
                                                   : $urandom_range(1, 64));
    g.text_rows = 6'(($urandom_range(0, 7) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(1, 32));
    g.scale = 3'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
    g.start_line = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 63));
    g.active_pixels = 11'($urandom_range(8, 2047));
    g.active_lines = 10'($urandom_range(8, 1023));
    return g;
  endfunction

  task automatic test_reset_geometry();
    send_item(make_item(CMD_SET_BORDER, 0, 16'hff5a));
    send_item(make_item(CMD_WR_GLYPH, 0, 16'hff81));
    send_item(make_item(CMD_WR_ATTR, 0, 16'hc33c));
    send_item(make_item(CMD_WR_ATTR, 16383, 16'hffff));
    send_item(make_item(CMD_WR_ATTR, ATTR_DEPTH, 16'h0000));
    render_at(48, 32);
    render_at(49, 33);
    render_at(48, 39);
    render_at(47, 32);
    render_at(0, 0);
    render_at(1023, 2047);
    render_at(48, 31);
    render_at(48, 288);
    render_at(431, 287);
    render_at(432, 287);
  endtask

  task automatic test_extreme_geometry();
    geom_cfg_t g;
    int sc, cols, rows, y0, ny, x0, nx;
    // oversized text area, saturated to the largest store
    g = '{7'd127, 6'd63, 3'd1, 10'd0, 11'd2047, 10'd1023};
    apply_geometry(g, 1'b1);
    text_window(sc, cols, rows, y0, ny, x0, nx);
    render_at((y0 + ny - 1) * sc, x0 + nx - 1);
    render_at(y0 * sc, x0);
    render_at((y0 + ny) * sc, x0 + nx);
    repeat (10) render_random();
    // smallest screen, zero scale, area at the very last line
    g = '{7'd1, 6'd1, 3'd0, 10'd1023, 11'd8, 10'd8};
    apply_geometry(g, 1'b0);
    render_at(1023, 0);
    render_at(1023, 7);
    render_at(1023, 8);
    render_at(1022, 0);
    // widest scale with text larger than the screen
    g = '{7'd64, 6'd32, 3'd7, 10'd5, 11'd8, 10'd8};
    apply_geometry(g, 1'b0);
    repeat (12) render_random();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      int stop_at;
      apply_geometry(random_geometry(), 1'b0);
      stop_at = requests_sent + count / 4;
      while (requests_sent < stop_at) random_request();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_geometry('{RST_TEXT_COLUMNS, RST_TEXT_ROWS, 3'd1, RST_START_LINE,
                     RST_ACTIVE_PIXELS, RST_ACTIVE_LINES}, 1'b0);
    hold_request++;
    repeat (80) render_random();
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    command = CMD_WR_GLYPH;
    address = '0;
    write_data = '0;
    video_line = '0;
    pixel_x = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TEXT_COLUMNS;
    cfg_data = '0;
    geom = '{RST_TEXT_COLUMNS, RST_TEXT_ROWS, RST_SCALE, RST_START_LINE,
             RST_ACTIVE_PIXELS, RST_ACTIVE_LINES};
    border_shadow = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_extreme_geometry();
    test_random_traffic(12, 57, 400);
    test_random_traffic(57, 12, 400);
    test_random_traffic(0, 0, 320);
    test_backpressure();

    @(negedge clk);
    cmd_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("[text_attribute_rasterizer_unit] OK");
    end else begin
      $display("[text_attribute_rasterizer_unit] ERROR");
    end
    $finish;
  end

endmodule
